@@ design/ccbm_pkg.sv @@
// Package: shared constants, widths and controller/datapath command types.
`timescale 1ns / 1ps
package ccbm_pkg;

  localparam int MAX_ATOMS_P = 1024;
  localparam int IDX_W       = $clog2(MAX_ATOMS_P);
  localparam int CNT_W       = IDX_W + 1;
  localparam int COORD_W     = 25;
  localparam int ABS_W       = COORD_W + 1;
  localparam int SQ_W        = 2 * ABS_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int THR_W       = 40;
  localparam int SCORE_W     = 20;
  localparam int OIDX_W      = 10;
  localparam int GAIN_W      = 12;
  localparam int NBR_W       = CNT_W;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(25000000);

  // Slot of the best-move trackers
  localparam int SLOT_U = 0;
  localparam int SLOT_V = 1;

  typedef struct packed {
    logic wr;
    logic start;
    logic rd_i;
    logic latch_i;
    logic issue_j;
    logic fold;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last_j;
    logic last_i;
    logic pipe_busy;
  } status_t;

endpackage

@@ design/ccbm_if.sv @@
// Interfaces: atom input channel and result output channel.
`timescale 1ns / 1ps
interface ccbm_atom_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] x_milli;
  logic signed [24:0] y_milli;
  logic signed [24:0] z_milli;
  logic               atom_class;
  logic               locked;
  logic               last_atom;
  modport source(output valid, x_milli, y_milli, z_milli, atom_class, locked, last_atom,
                 input ready);
  modport sink(input valid, x_milli, y_milli, z_milli, atom_class, locked, last_atom,
               output ready);
endinterface

interface ccbm_result_if;
  logic               valid;
  logic               ready;
  logic [19:0]        contact_score;
  logic               to_u_found;
  logic [9:0]         to_u_index;
  logic signed [11:0] to_u_gain;
  logic               to_v_found;
  logic [9:0]         to_v_index;
  logic signed [11:0] to_v_gain;
  logic               overflow;
  modport source(output valid, contact_score, to_u_found, to_u_index, to_u_gain,
                 to_v_found, to_v_index, to_v_gain, overflow, input ready);
  modport sink(input valid, contact_score, to_u_found, to_u_index, to_u_gain,
               to_v_found, to_v_index, to_v_gain, overflow, output ready);
endinterface

@@ design/ccbm_ctrl.sv @@
// Controller: sequences load, pair sweep per atom, fold and result hand-off.
`timescale 1ns / 1ps
module ccbm_ctrl
  import ccbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  input  logic    res_free,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD_I, S_LATCH_I, S_SWEEP, S_DRAIN, S_FOLD, S_DONE
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.wr       = accept;
    cmd.start    = accept && in_last;
    cmd.rd_i     = (state == S_RD_I);
    cmd.latch_i  = (state == S_LATCH_I);
    cmd.issue_j  = (state == S_SWEEP);
    cmd.fold     = (state == S_FOLD);
    cmd.load_out = (state == S_DONE) && res_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:    if (accept && in_last) state <= S_RD_I;
        S_RD_I:    state <= S_LATCH_I;
        S_LATCH_I: state <= S_SWEEP;
        S_SWEEP:   if (status.last_j) state <= S_DRAIN;
        S_DRAIN:   if (!status.pipe_busy) state <= S_FOLD;
        S_FOLD:    state <= status.last_i ? S_DONE : S_RD_I;
        S_DONE:    if (res_free) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/ccbm_datapath.sv @@
// Datapath: atom memory, distance pipeline, neighbour counters, best-move trackers.
`timescale 1ns / 1ps
module ccbm_datapath
  import ccbm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  logic [THR_W-1:0]          thr,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic signed [COORD_W-1:0] in_z,
  input  logic                      in_class,
  input  logic                      in_lock,
  output status_t                   status,
  output logic [SCORE_W-1:0]        r_score,
  output logic [1:0]                r_found,
  output logic [OIDX_W-1:0]         r_idx_u,
  output logic [OIDX_W-1:0]         r_idx_v,
  output logic signed [GAIN_W-1:0]  r_gain_u,
  output logic signed [GAIN_W-1:0]  r_gain_v,
  output logic                      r_overflow
);

  localparam int ENT_W = 3 * COORD_W + 2;

  logic [ENT_W-1:0] mem [MAX_ATOMS_P];
  logic [ENT_W-1:0] rdata;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] atom_count;
  logic             overflow_seen;
  logic [IDX_W-1:0] i_idx, j_idx;

  logic signed [COORD_W-1:0] ix, iy, iz;
  logic                      icls, ilock;

  // pipeline registers
  logic              v1, v2, v3, v4;
  logic [IDX_W-1:0]  j1;
  logic [ABS_W-1:0]  ax, ay, az;
  logic              self2, cls2, self3, cls3, self4, cls4, hit4;
  logic [SQ_W-1:0]   sx, sy, sz;

  logic signed [COORD_W-1:0] jx, jy, jz;
  logic signed [ABS_W-1:0]   dx, dy, dz;
  logic [SUM_W-1:0]          dsum;

  logic [NBR_W-1:0]          same_cnt, cross_cnt;
  logic [SCORE_W-1:0]        score;
  logic [1:0]                found;
  logic [IDX_W-1:0]          best_idx [2];
  logic signed [GAIN_W-1:0]  best_gain [2];
  logic signed [NBR_W+1:0]   ndiff;
  logic signed [GAIN_W-1:0]  gain;
  logic                      slot;

  assign rd_addr = cmd.rd_i ? i_idx : j_idx;

  always_ff @(posedge clk) begin
    if (cmd.wr && (atom_count < CNT_W'(MAX_ATOMS_P)))
      mem[atom_count[IDX_W-1:0]] <= {in_x, in_y, in_z, in_lock, in_class};
    rdata <= mem[rd_addr];
  end

  assign jx = rdata[ENT_W-1 -: COORD_W];
  assign jy = rdata[ENT_W-1-COORD_W -: COORD_W];
  assign jz = rdata[ENT_W-1-2*COORD_W -: COORD_W];

  assign dx = ABS_W'(jx) - ABS_W'(ix);
  assign dy = ABS_W'(jy) - ABS_W'(iy);
  assign dz = ABS_W'(jz) - ABS_W'(iz);

  assign dsum = SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);

  assign status.last_j    = ({1'b0, j_idx} == atom_count - CNT_W'(1));
  assign status.last_i    = ({1'b0, i_idx} == atom_count - CNT_W'(1));
  assign status.pipe_busy = v1 | v2 | v3 | v4;

  assign ndiff = $signed({2'b00, same_cnt}) - $signed({2'b00, cross_cnt});
  assign gain  = {ndiff[GAIN_W-2:0], 1'b0};
  assign slot  = icls ? 1'(SLOT_U) : 1'(SLOT_V);

  // control counters and valids
  always_ff @(posedge clk) begin
    if (rst) begin
      atom_count    <= '0;
      overflow_seen <= 1'b0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      found <= '0;
    end else begin
      if (cmd.wr) begin
        if (atom_count < CNT_W'(MAX_ATOMS_P)) atom_count <= atom_count + CNT_W'(1);
        else overflow_seen <= 1'b1;
      end
      if (cmd.load_out) begin
        atom_count    <= '0;
        overflow_seen <= 1'b0;
      end
      v1 <= cmd.issue_j;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (cmd.start) found <= '0;
      else if (cmd.fold && !ilock && (!found[slot] || gain < best_gain[slot]))
        found[slot] <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i_idx <= '0;
      score <= '0;
      best_idx[0] <= '0; best_idx[1] <= '0;
      best_gain[0] <= '0; best_gain[1] <= '0;
    end
    if (cmd.latch_i) begin
      ix <= jx; iy <= jy; iz <= jz;
      ilock <= rdata[1];
      icls  <= rdata[0];
      j_idx <= '0;
      same_cnt  <= '0;
      cross_cnt <= '0;
    end
    if (cmd.issue_j) j_idx <= j_idx + IDX_W'(1);
    j1 <= j_idx;
    // stage: absolute differences
    ax <= dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    ay <= dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    az <= dz[ABS_W-1] ? ABS_W'(-dz) : ABS_W'(dz);
    self2 <= (j1 == i_idx);
    cls2  <= rdata[0];
    // stage: squares
    sx <= ax * ax;
    sy <= ay * ay;
    sz <= az * az;
    self3 <= self2;
    cls3  <= cls2;
    // stage: threshold compare
    hit4  <= (dsum < SUM_W'(thr));
    self4 <= self3;
    cls4  <= cls3;
    // stage: neighbour counts
    if (v4 && hit4 && !self4) begin
      if (cls4 == icls) same_cnt  <= same_cnt + NBR_W'(1);
      else              cross_cnt <= cross_cnt + NBR_W'(1);
    end
    if (cmd.fold) begin
      score <= score + SCORE_W'(cross_cnt);
      i_idx <= i_idx + IDX_W'(1);
      if (!ilock && (!found[slot] || gain < best_gain[slot])) begin
        best_idx[slot]  <= i_idx;
        best_gain[slot] <= gain;
      end
    end
    if (cmd.load_out) begin
      r_score    <= score;
      r_found    <= found;
      r_idx_u    <= OIDX_W'(best_idx[SLOT_U]);
      r_idx_v    <= OIDX_W'(best_idx[SLOT_V]);
      r_gain_u   <= best_gain[SLOT_U];
      r_gain_v   <= best_gain[SLOT_V];
      r_overflow <= overflow_seen;
    end
  end

endmodule

@@ design/contact_cut_best_move.sv @@
// Top level: contact cut best move engine with APB threshold register.
//
//  channel  dir  beat                                    handshake
//  atoms    in   one atom: xyz, class, lock, last flag   valid/ready
//  result   out  score, best to_u / to_v moves, overflow valid/ready
//  apb      in   contact_dist_sq at byte address 0       psel/penable
//
// Atoms load at one beat per cycle into a 1024-entry memory. The beat with
// last_atom set starts the sweep: for each stored atom i, one read to fetch it,
// then n reads of atom j through a four-stage distance pipeline (abs diff,
// square, sum/compare, count), drain and fold. Input ready is low during the
// sweep. The result sits in an output register until taken; loading of the
// next set proceeds meanwhile. Synchronous reset clears control state and
// sets the threshold to five angstrom; the memory is not cleared.
`timescale 1ns / 1ps
module contact_cut_best_move
  import ccbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ccbm_atom_if.sink    atoms,
  ccbm_result_if.source result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  logic [THR_W-1:0] contact_dist_sq;
  cmd_t             cmd;
  status_t          status;
  logic             res_free;
  logic             res_valid;
  logic [1:0]       found;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? 64'd0 : {{(64-THR_W){1'b0}}, contact_dist_sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_dist_sq <= THR_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      contact_dist_sq <= pwdata[THR_W-1:0];
    end
  end

  // output holding register: free when empty or being taken this cycle
  assign res_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result.valid      = res_valid;
  assign result.to_u_found = found[SLOT_U];
  assign result.to_v_found = found[SLOT_V];

  ccbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (atoms.valid),
    .in_last  (atoms.last_atom),
    .res_free (res_free),
    .status   (status),
    .in_ready (atoms.ready),
    .cmd      (cmd)
  );

  ccbm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .thr        (contact_dist_sq),
    .in_x       (atoms.x_milli),
    .in_y       (atoms.y_milli),
    .in_z       (atoms.z_milli),
    .in_class   (atoms.atom_class),
    .in_lock    (atoms.locked),
    .status     (status),
    .r_score    (result.contact_score),
    .r_found    (found),
    .r_idx_u    (result.to_u_index),
    .r_idx_v    (result.to_v_index),
    .r_gain_u   (result.to_u_gain),
    .r_gain_v   (result.to_v_gain),
    .r_overflow (result.overflow)
  );

endmodule
